@@ hw/rtl/absb_pkg.sv @@
// ----------------------------------------------------------------------------
// absb_pkg
// Shared types and constants of the alpha blend sprite blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package absb_pkg;

	// Frame store geometry
	localparam int ADDR_W   = 16;
	localparam int DEPTH    = 65536;
	localparam int PIX_W    = 32;
	// Signed canvas coordinate: covers dest + pos and canvas sizes up to 4096
	localparam int COORD_W  = 14;
	// Row times canvas width plus column, before wrapping to the store depth
	localparam int MUL_W    = 23;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
	localparam int         BYTE_SHIFT   = 8;

	typedef enum logic [1:0] {
		ACT_BLIT = 2'd0,
		ACT_PLOT = 2'd1,
		ACT_READ = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_CLIPPED = 2'd1,
		ST_TRANSP  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		REG_DEST_X   = 3'd0,
		REG_DEST_Y   = 3'd1,
		REG_SPRITE_W = 3'd2,
		REG_SPRITE_H = 3'd3,
		REG_WINDOW_W = 3'd4,
		REG_WINDOW_H = 3'd5,
		REG_FADE     = 3'd6
	} reg_index_t;

	// What the modify stage does with the entry it gets
	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_WRITE = 2'd1,
		OP_BLEND = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef struct packed {
		logic signed [8:0] dest_x;
		logic signed [8:0] dest_y;
		logic [8:0]        sprite_width;
		logic [8:0]        sprite_height;
		logic [8:0]        window_width;
		logic [8:0]        window_height;
		logic [7:0]        fade;
	} cfg_t;

	// Decoded item handed from the front end to the modify stage
	typedef struct packed {
		op_t               op;
		status_t           status;
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  color;
		logic [7:0]        alpha;
	} item_t;

endpackage

`default_nettype wire

@@ hw/rtl/alpha_blend_sprite_blitter_core.sv @@
// ----------------------------------------------------------------------------
// alpha_blend_sprite_blitter_core
// Sprite blitter with clipping, alpha fade and blending onto a frame store.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one transaction per item. tuser carries the action (blit,
//   plot, read); tdata carries the sprite or canvas position and the pixel.
//   m_* channel: exactly one result transaction per item, in order. tdata is
//   the pixel written (or read back), tuser holds the wrote flag and status.
//   cfg_* channel: register writes (placement, sprite and window size, fade);
//   always ready. Write registers only while no item is in flight.
// Timing:
//   One item per cycle sustained while m_tready is high. An item passes the
//   read stage and the output register before its result shows on m_tvalid.
//   The store is read when the item is taken and written back as it leaves
//   the read stage; that write is forwarded to a following read of the same
//   address, so back-to-back blits onto one pixel blend correctly.
// Reset:
//   arst_n clears the config registers and pipeline valid flags. The frame store is
//   not cleared: plot pixels before reading or blending onto them.
// Stall:
//   When m_tready is low, the result holds in the output register, one more
//   item may enter the read stage, and then s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module alpha_blend_sprite_blitter_core #(
	parameter int CANVAS_WIDTH  = 256,
	parameter int CANVAS_HEIGHT = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input items
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,  // pos_x[7:0], pos_y[15:8], color[47:16]
	input  wire logic [1:0]  s_tuser,  // action[1:0]
	// Results
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // pixel[31:0]
	output logic [2:0]       m_tuser,  // wrote[0], status[2:1]
	// Configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [8:0]  cfg_data
);
	import absb_pkg::*;

	cfg_t              cfg_q;
	item_t             front_item;
	item_t             item_s1;
	logic              valid_s1;
	logic              fwd_s1;
	logic [PIX_W-1:0]  fwd_data_s1;
	logic [PIX_W-1:0]  ram_rdata;
	logic [PIX_W-1:0]  dst;
	logic              blend_we;
	logic              ram_we;
	logic [PIX_W-1:0]  res_pixel;
	logic              res_wrote;
	status_t           res_status;
	logic              s1_move;
	logic              accept;
	logic              out_valid_q;
	logic [PIX_W-1:0]  out_pixel_q;
	logic              out_wrote_q;
	status_t           out_status_q;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEST_X:   cfg_q.dest_x        <= $signed(cfg_data);
				REG_DEST_Y:   cfg_q.dest_y        <= $signed(cfg_data);
				REG_SPRITE_W: cfg_q.sprite_width  <= cfg_data;
				REG_SPRITE_H: cfg_q.sprite_height <= cfg_data;
				REG_WINDOW_W: cfg_q.window_width  <= cfg_data;
				REG_WINDOW_H: cfg_q.window_height <= cfg_data;
				REG_FADE:     cfg_q.fade          <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Decode the incoming item and issue the frame store read
	absb_front #(
		.CANVAS_WIDTH (CANVAS_WIDTH),
		.CANVAS_HEIGHT(CANVAS_HEIGHT)
	) u_front (
		.cfg   (cfg_q),
		.action(s_tuser),
		.pos_x (s_tdata[7:0]),
		.pos_y (s_tdata[15:8]),
		.color (s_tdata[47:16]),
		.item  (front_item)
	);

	// Advance the read stage whenever the output register is free or drains
	assign s1_move  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || s1_move;
	assign accept   = s_tvalid && s_tready;

	// Write back only as the item leaves the read stage, so it writes once
	assign ram_we = valid_s1 && s1_move && blend_we;

	absb_ram #(
		.WIDTH(PIX_W),
		.DEPTH(DEPTH)
	) u_frame_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(item_s1.addr),
		.wdata(res_pixel),
		.re   (accept),
		.raddr(front_item.addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the item and the same-cycle write for forwarding; hold on stall
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1     <= front_item;
			fwd_s1      <= ram_we && (item_s1.addr == front_item.addr);
			fwd_data_s1 <= res_pixel;
		end
	end

	// The store reads old data when read and written at once: take the write
	assign dst = fwd_s1 ? fwd_data_s1 : ram_rdata;

	absb_blend u_blend (
		.item  (item_s1),
		.dst   (dst),
		.we    (blend_we),
		.pixel (res_pixel),
		.wrote (res_wrote),
		.status(res_status)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && valid_s1) begin
			out_pixel_q  <= res_pixel;
			out_wrote_q  <= res_wrote;
			out_status_q <= res_status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_pixel_q;
	assign m_tuser  = {out_status_q, out_wrote_q};

endmodule

`default_nettype wire

@@ hw/rtl/absb_ram.sv @@
// ----------------------------------------------------------------------------
// absb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module absb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/absb_front.sv @@
// ----------------------------------------------------------------------------
// absb_front
// Decode one item: clip, fade the alpha, form the frame store address.
// ----------------------------------------------------------------------------
`default_nettype none

module absb_front #(
	parameter int CANVAS_WIDTH  = 256,
	parameter int CANVAS_HEIGHT = 256
) (
	input  wire absb_pkg::cfg_t  cfg,
	input  wire logic [1:0]      action,
	input  wire logic [7:0]      pos_x,
	input  wire logic [7:0]      pos_y,
	input  wire logic [31:0]     color,
	output absb_pkg::item_t      item
);
	import absb_pkg::*;

	localparam logic signed [COORD_W-1:0] CW_S = COORD_W'(CANVAS_WIDTH);
	localparam logic signed [COORD_W-1:0] CH_S = COORD_W'(CANVAS_HEIGHT);

	logic signed [COORD_W-1:0] cx, cy;
	logic                      ok_x, ok_y, in_canvas;
	logic [7:0]                a_src, a_faded;
	logic [8:0]                col, row;
	logic [MUL_W-1:0]          addr_full;

	always_comb begin
		cx = $signed({{(COORD_W-9){cfg.dest_x[8]}}, cfg.dest_x})
			+ $signed({{(COORD_W-8){1'b0}}, pos_x});
		cy = $signed({{(COORD_W-9){cfg.dest_y[8]}}, cfg.dest_y})
			+ $signed({{(COORD_W-8){1'b0}}, pos_y});

		ok_x = ({1'b0, pos_x} < cfg.sprite_width)
			&& (cfg.window_width == '0 || {1'b0, pos_x} < cfg.window_width)
			&& (cx >= 0) && (cx < CW_S);
		ok_y = ({1'b0, pos_y} < cfg.sprite_height)
			&& (cfg.window_height == '0 || {1'b0, pos_y} < cfg.window_height)
			&& (cy >= 0) && (cy < CH_S);

		in_canvas = (COORD_W'(pos_x) < COORD_W'(CANVAS_WIDTH))
			&& (COORD_W'(pos_y) < COORD_W'(CANVAS_HEIGHT));

		a_src   = color[31:24];
		a_faded = (cfg.fade >= a_src) ? 8'd0 : a_src - cfg.fade;

		// Clipped blit coordinates are non-negative and below 511
		if (action == ACT_BLIT) begin
			col = cx[8:0];
			row = cy[8:0];
		end else begin
			col = {1'b0, pos_x};
			row = {1'b0, pos_y};
		end
		addr_full = MUL_W'(row) * MUL_W'(CANVAS_WIDTH) + MUL_W'(col);

		item.op     = OP_NONE;
		item.status = ST_DONE;
		item.addr   = addr_full[ADDR_W-1:0];
		item.color  = color;
		item.alpha  = a_faded;

		case (action)
			ACT_BLIT: begin
				if (!ok_x || !ok_y) begin
					item.status = ST_CLIPPED;
				end else if (a_faded == 8'd0) begin
					item.status = ST_TRANSP;
				end else if (a_faded == ALPHA_OPAQUE) begin
					item.op    = OP_WRITE;
					item.color = {ALPHA_OPAQUE, color[23:0]};
				end else begin
					item.op = OP_BLEND;
				end
			end
			ACT_PLOT: begin
				if (!in_canvas) begin
					item.status = ST_CLIPPED;
				end else begin
					item.op = OP_WRITE;
				end
			end
			ACT_READ: begin
				if (!in_canvas) begin
					item.status = ST_CLIPPED;
				end else begin
					item.op = OP_READ;
				end
			end
			default: begin
				item.op = OP_NONE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/absb_blend.sv @@
// ----------------------------------------------------------------------------
// absb_blend
// Modify step: blend, overwrite or pass the stored pixel; form the result.
// ----------------------------------------------------------------------------
`default_nettype none

module absb_blend (
	input  wire absb_pkg::item_t item,
	input  wire logic [31:0]     dst,
	output logic                 we,
	output logic [31:0]          pixel,
	output logic                 wrote,
	output absb_pkg::status_t    status
);
	import absb_pkg::*;

	logic [7:0]  inv;
	logic [15:0] mix [3];
	logic [31:0] blended;

	always_comb begin
		inv = ALPHA_OPAQUE - item.alpha;
		blended[31:24] = dst[31:24];
		for (int i = 0; i < 3; i++) begin
			mix[i] = 16'(dst[i*8 +: 8]) * 16'(inv)
				+ 16'(item.color[i*8 +: 8]) * 16'(item.alpha);
			blended[i*8 +: 8] = mix[i][BYTE_SHIFT +: 8];
		end

		status = item.status;
		case (item.op)
			OP_WRITE: begin
				we    = 1'b1;
				pixel = item.color;
				wrote = 1'b1;
			end
			OP_BLEND: begin
				we    = 1'b1;
				pixel = blended;
				wrote = 1'b1;
			end
			OP_READ: begin
				we    = 1'b0;
				pixel = dst;
				wrote = 1'b0;
			end
			default: begin
				we    = 1'b0;
				pixel = '0;
				wrote = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/absb_checker.sv @@
// ----------------------------------------------------------------------------
// absb_checker
// Port-level checks of the sprite blitter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module absb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [2:0]  m_tuser
);
	import absb_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// A write is always reported as done
	a_wrote_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tuser[2:1] == ST_DONE)
		else $error("write with non-done status");

	// Clipped or transparent items carry a zero pixel
	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2:1] != ST_DONE |-> m_tdata == '0 && !m_tuser[0])
		else $error("skipped item carries data");

	// A fresh result must follow an accepted input transaction
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without matching input");

endmodule

bind alpha_blend_sprite_blitter_core absb_checker u_absb_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

`default_nettype wire
